>>> sv/wrcs_pkg.sv
// Package with the shared types and constants of the wheel residue-class sieve.
`timescale 1ns / 1ps
`default_nettype none
package wrcs_pkg;

  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int MARK_WORD_W = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_SIEVE_MODULUS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESIDUE_OFFSET = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_LENGTH = 2'd2;

  localparam logic [19:0] MODULUS_RESET = 20'd210;
  localparam logic [19:0] OFFSET_RESET  = 20'd1;
  localparam logic [16:0] LENGTH_RESET  = 17'd65536;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_SIEVE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [19:0] prime;
    logic [19:0] start_multiplier;
    logic [9:0]  word_address;
  } item_t;

  typedef struct packed {
    logic [63:0] read_word;
    logic [16:0] marks_made;
    logic [19:0] first_index;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL_START,
    ST_DIV,
    ST_MUL_CHECK,
    ST_ADJUST,
    ST_LOOP,
    ST_MARK_RD,
    ST_MARK_LD,
    ST_MARK_SET,
    ST_RD_WRAP,
    ST_RD_RD,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> sv/wrcs_mark_ram.sv
// Single-port-write, registered-read memory holding the composite marks.
`timescale 1ns / 1ps
`default_nettype none
module wrcs_mark_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [ADDR_W-1:0]               waddr,
  input  wire logic [wrcs_pkg::MARK_WORD_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]               raddr,
  output logic      [wrcs_pkg::MARK_WORD_W-1:0] rdata
);

  logic [wrcs_pkg::MARK_WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/wheel_residue_class_sieve.sv
// Top level of the wheel residue-class sieve: configuration, sequencer and shared arithmetic.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps one bit of composite mark per index of a wheel residue class in a
// memory of SEGMENT_BITS/64 words and works on one transaction at a time: busy is high
// from acceptance until the cycle after the done strobe, and done carries the result for
// exactly one cycle, so the receiver must take it then. After reset a clearing pass over
// all SEGMENT_BITS/64 words runs with busy high. A clear writes one memory word per cycle.
// A read first takes the address down by the memory depth until it lies inside the
// memory, then reads the word. A sieve forms a product in the shared multiplier, reduces
// it modulo the prime bit-serially in the subtractor, passes through the shared
// multiplier again for the start adjustment, then marks each index in turn, reading,
// loading and writing back each memory word touched, so its length follows the data.
module wheel_residue_class_sieve #(
  parameter int SEGMENT_BITS = 65536,
  parameter int PRIME_WIDTH  = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire wrcs_pkg::item_t                     item,
  output logic                                     done,
  output wrcs_pkg::result_t                        result,
  input  wire logic                                cfg_we,
  input  wire logic [wrcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [wrcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WORD_COUNT = SEGMENT_BITS / 64;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PW         = PRIME_WIDTH;
  localparam int PROD_W     = PW + 20;
  localparam int CNT_W      = $clog2(PROD_W + 1);
  localparam int LEN_W      = $clog2(SEGMENT_BITS + 1);
  localparam int LW         = (LEN_W > 17) ? LEN_W : 17;
  localparam int JW         = ((PW + 1 > LW) ? PW + 1 : LW) + 1;
  localparam int WRAP       = (WORD_COUNT >= 1024) ? 1024 : WORD_COUNT;

  localparam logic [AW-1:0]    LAST_WORD = AW'(WORD_COUNT - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(PROD_W - 1);
  localparam logic [LW-1:0]    SEG_MAX   = LW'(SEGMENT_BITS);
  localparam logic [10:0]      WRAP_LIM  = 11'(WRAP);

  // Configuration registers.
  logic [19:0] sieve_modulus;
  logic [19:0] residue_offset;
  logic [16:0] segment_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_modulus  <= wrcs_pkg::MODULUS_RESET;
      residue_offset <= wrcs_pkg::OFFSET_RESET;
      segment_length <= wrcs_pkg::LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wrcs_pkg::CFG_SIEVE_MODULUS:  sieve_modulus  <= cfg_data;
        wrcs_pkg::CFG_RESIDUE_OFFSET: residue_offset <= cfg_data;
        wrcs_pkg::CFG_SEGMENT_LENGTH: segment_length <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  wrcs_pkg::state_t state, state_next;

  logic              accept;
  logic [PW-1:0]     prime_r;
  logic [PW-1:0]     mult_r;
  logic [9:0]        raddr;
  logic              clear_mark;
  logic              sweep_item;
  logic [AW-1:0]     clr_addr;
  logic [PROD_W-1:0] prod;
  logic [PW:0]       rem;
  logic [CNT_W-1:0]  cnt;
  logic [JW-1:0]     j;
  logic [63:0]       word_buf;
  wrcs_pkg::result_t res;

  // Shared arithmetic.
  logic [PW-1:0]     mul_a;
  logic [19:0]       mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PW:0]       div_sh;
  logic              div_ge;
  logic [PROD_W:0]   chk_sum;
  logic              chk_eq;
  logic [PW:0]       start_v;
  logic [LW-1:0]     seg_ext;
  logic [LW-1:0]     len;
  logic [JW-1:0]     j_nx;
  logic              j_in;
  logic              j_nx_in;
  logic              same_word;
  logic [63:0]       word_new;

  // Memory control.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_rdata;

  assign accept = start && !busy;

  assign mul_a = (state == wrcs_pkg::ST_MUL_START) ? mult_r : rem[PW-1:0];
  assign mul_b = (state == wrcs_pkg::ST_MUL_START) ? residue_offset : sieve_modulus;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign div_sh = {rem[PW-1:0], prod[PROD_W-1]};
  assign div_ge = div_sh >= {1'b0, prime_r};

  assign chk_sum = (PROD_W+1)'(prod) + (PROD_W+1)'(residue_offset);
  assign chk_eq  = chk_sum == (PROD_W+1)'(prime_r);
  assign start_v = {1'b0, rem[PW-1:0]} + (chk_eq ? {1'b0, prime_r} : '0);

  assign seg_ext = LW'(segment_length);
  assign len     = (seg_ext > SEG_MAX) ? SEG_MAX : seg_ext;

  assign j_nx      = j + JW'(prime_r);
  assign j_in      = j < JW'(len);
  assign j_nx_in   = j_nx < JW'(len);
  assign same_word = j_nx[JW-1:6] == j[JW-1:6];
  assign word_new  = word_buf | (64'd1 << j[5:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrcs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = '0;
    mem_raddr  = AW'(raddr);
    case (state)
      wrcs_pkg::ST_IDLE: begin
        if (accept) begin
          case (item.mode)
            wrcs_pkg::MODE_CLEAR: state_next = wrcs_pkg::ST_CLEAR;
            wrcs_pkg::MODE_SIEVE: begin
              state_next = (PW'(item.prime) == '0) ? wrcs_pkg::ST_DONE
                                                    : wrcs_pkg::ST_MUL_START;
            end
            wrcs_pkg::MODE_READ:  state_next = wrcs_pkg::ST_RD_WRAP;
            default:              state_next = wrcs_pkg::ST_DONE;
          endcase
        end
      end
      wrcs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {63'd0, clear_mark && (clr_addr == '0)};
        if (clr_addr == LAST_WORD) begin
          state_next = sweep_item ? wrcs_pkg::ST_DONE : wrcs_pkg::ST_IDLE;
        end
      end
      wrcs_pkg::ST_MUL_START: state_next = wrcs_pkg::ST_DIV;
      wrcs_pkg::ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = wrcs_pkg::ST_MUL_CHECK;
        end
      end
      wrcs_pkg::ST_MUL_CHECK: state_next = wrcs_pkg::ST_ADJUST;
      wrcs_pkg::ST_ADJUST:    state_next = wrcs_pkg::ST_LOOP;
      wrcs_pkg::ST_LOOP: begin
        state_next = j_in ? wrcs_pkg::ST_MARK_RD : wrcs_pkg::ST_DONE;
      end
      wrcs_pkg::ST_MARK_RD: begin
        mem_raddr  = AW'(j >> 6);
        state_next = wrcs_pkg::ST_MARK_LD;
      end
      wrcs_pkg::ST_MARK_LD: state_next = wrcs_pkg::ST_MARK_SET;
      wrcs_pkg::ST_MARK_SET: begin
        // Marks within one word gather in the buffer; it goes back when the walk leaves it.
        if (!(j_nx_in && same_word)) begin
          mem_we     = 1'b1;
          mem_waddr  = AW'(j >> 6);
          mem_wdata  = word_new;
          state_next = j_nx_in ? wrcs_pkg::ST_MARK_RD : wrcs_pkg::ST_DONE;
        end
      end
      wrcs_pkg::ST_RD_WRAP: begin
        if ({1'b0, raddr} < WRAP_LIM) begin
          state_next = wrcs_pkg::ST_RD_RD;
        end
      end
      wrcs_pkg::ST_RD_RD:   state_next = wrcs_pkg::ST_RD_WAIT;
      wrcs_pkg::ST_RD_WAIT: state_next = wrcs_pkg::ST_DONE;
      wrcs_pkg::ST_DONE:    state_next = wrcs_pkg::ST_IDLE;
      default:              state_next = wrcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clear_mark <= 1'b0;
      sweep_item <= 1'b0;
    end else begin
      case (state)
        wrcs_pkg::ST_IDLE: begin
          if (accept) begin
            clr_addr   <= '0;
            clear_mark <= residue_offset == 20'd1;
            sweep_item <= 1'b1;
          end
        end
        wrcs_pkg::ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      wrcs_pkg::ST_IDLE: begin
        if (accept) begin
          prime_r <= PW'(item.prime);
          mult_r  <= PW'(item.start_multiplier);
          raddr   <= item.word_address;
          res     <= '0;
        end
      end
      wrcs_pkg::ST_MUL_START: begin
        prod <= mul_p;
        rem  <= '0;
        cnt  <= '0;
      end
      wrcs_pkg::ST_DIV: begin
        // One quotient bit per cycle; the remainder always stays below the prime.
        rem  <= div_ge ? (div_sh - {1'b0, prime_r}) : div_sh;
        prod <= prod << 1;
        cnt  <= cnt + CNT_W'(1);
      end
      wrcs_pkg::ST_MUL_CHECK: prod <= mul_p;
      wrcs_pkg::ST_ADJUST: begin
        j               <= JW'(start_v);
        res.first_index <= 20'(start_v);
      end
      wrcs_pkg::ST_MARK_LD: word_buf <= mem_rdata;
      wrcs_pkg::ST_MARK_SET: begin
        word_buf       <= word_new;
        j              <= j_nx;
        res.marks_made <= res.marks_made + 17'd1;
      end
      wrcs_pkg::ST_RD_WRAP: begin
        if ({1'b0, raddr} >= WRAP_LIM) begin
          raddr <= 10'({1'b0, raddr} - WRAP_LIM);
        end
      end
      wrcs_pkg::ST_RD_WAIT: res.read_word <= mem_rdata;
      default: ;
    endcase
  end

  wrcs_mark_ram #(
    .DEPTH  (WORD_COUNT),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = state != wrcs_pkg::ST_IDLE;
  assign done   = state == wrcs_pkg::ST_DONE;
  assign result = res;

endmodule
`default_nettype wire

>>> sv/wrcs_checker.sv
// Port-level checker for the sieve's command handshake, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wrcs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // A result is only ever shown while the transaction is still in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done strobe seen while the block is not busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe lasted more than one cycle");

  a_done_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block stayed busy after delivering its result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted transaction did not make the block busy");

endmodule

bind wheel_residue_class_sieve wrcs_checker u_wrcs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire
